FILE: hw/rtl/abkf_pkg.sv
// Package for the angle/bias Kalman filter: widths, reset values, register
// indexes, datapath operation codes, control structs and saturation helpers.
// No dependencies.
package abkf_pkg;

   localparam int VAL_W    = 32;
   localparam int COV_W    = 48;
   localparam int WIDE_W   = 62;
   localparam int DT_W     = 17;
   localparam int MAG_W    = 51;
   localparam int CHUNK_W  = 17;
   localparam int NCHUNK   = MAG_W / CHUNK_W;
   localparam int PROD_W   = 2 * MAG_W;
   localparam int RES_W    = PROD_W - 16;
   localparam int NUM_W    = 48;
   localparam int DEN_W    = 50;
   localparam int DIVN_W   = NUM_W + 34;
   localparam int NOISE_SH = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [31:0] Q_ANGLE_RST    = 32'd16777;
   localparam logic [31:0] Q_BIAS_RST     = 32'd50332;
   localparam logic [31:0] MEAS_NOISE_RST = 32'd503316;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Q_ANGLE    = 2'd0,
      CSR_Q_BIAS     = 2'd1,
      CSR_MEAS_NOISE = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RATE,
      OP_M_ANG,
      OP_M_BB,
      OP_M_INNER,
      OP_M_QB,
      OP_D_K0,
      OP_D_K1,
      OP_M_K0Y,
      OP_M_K1Y,
      OP_M_K0P00,
      OP_M_K0P01,
      OP_M_K1P00,
      OP_M_K1P01
   } op_type;

   typedef struct packed {
      logic   capture;
      logic   start;
      logic   wb;
      logic   emit;
      op_type op;
   } abkf_cmd_type;

   typedef struct packed {
      logic done;
   } abkf_sts_type;

   function automatic op_type next_op(input op_type op);
      op_type n;
      case (op)
         OP_RATE:    n = OP_M_ANG;
         OP_M_ANG:   n = OP_M_BB;
         OP_M_BB:    n = OP_M_INNER;
         OP_M_INNER: n = OP_M_QB;
         OP_M_QB:    n = OP_D_K0;
         OP_D_K0:    n = OP_D_K1;
         OP_D_K1:    n = OP_M_K0Y;
         OP_M_K0Y:   n = OP_M_K1Y;
         OP_M_K1Y:   n = OP_M_K0P00;
         OP_M_K0P00: n = OP_M_K0P01;
         OP_M_K0P01: n = OP_M_K1P00;
         OP_M_K1P00: n = OP_M_K1P01;
         default:    n = OP_NONE;
      endcase
      return n;
   endfunction

   // sign and magnitude to signed value, clamped to w bits
   function automatic logic signed [63:0] sat_mag(input logic neg,
                                                  input logic [RES_W-1:0] m,
                                                  input int w);
      logic [RES_W-1:0] lim;
      logic [63:0]      v;
      lim = (RES_W'(1) << (w - 1)) - (neg ? RES_W'(0) : RES_W'(1));
      v = (m > lim) ? lim[63:0] : m[63:0];
      return neg ? -$signed(v) : $signed(v);
   endfunction

   function automatic logic signed [63:0] sat_val(input logic signed [63:0] v,
                                                  input int w);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [63:0] v);
      logic [63:0] a;
      a = v[63] ? 64'(-v) : 64'(v);
      return a[MAG_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/abkf_if.sv
// Channel interfaces of the angle/bias Kalman filter: step request, result
// and register write. No dependencies.
interface abkf_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] measured_angle;
   logic signed [31:0] gyro_rate;
   logic [16:0]        time_step;
   modport source (output valid, command, measured_angle, gyro_rate, time_step,
                   input ready);
   modport sink   (input valid, command, measured_angle, gyro_rate, time_step,
                   output ready);
endinterface

interface abkf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] filtered_angle;
   logic signed [31:0] unbiased_rate;
   modport source (output valid, filtered_angle, unbiased_rate, input ready);
   modport sink   (input valid, filtered_angle, unbiased_rate, output ready);
endinterface

interface abkf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/abkf_mul.sv
// Sequential magnitude multiplier with rounding shift: 51x17 partial product
// per cycle, three chunks, then round and shift by 16 or 32. Uses abkf_pkg.
module abkf_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [abkf_pkg::MAG_W-1:0] a,
   input  logic [abkf_pkg::MAG_W-1:0] b,
   input  logic                       sh32,
   output logic                       done,
   output logic [abkf_pkg::RES_W-1:0] res
);
   import abkf_pkg::*;

   logic                busy_ff, busy_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [MAG_W-1:0]    a_ff, a_in;
   logic [MAG_W-1:0]    b_ff, b_in;
   logic                sh32_ff, sh32_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic                done_ff, done_in;
   logic [MAG_W+CHUNK_W-1:0] part;
   logic [PROD_W-1:0]   part_sh;
   logic [PROD_W-1:0]   rsum;

   assign part = a_ff * b_ff[CHUNK_W-1:0];

   always_comb begin
      case (cnt_ff)
         2'd0:    part_sh = PROD_W'(part);
         2'd1:    part_sh = PROD_W'(part) << CHUNK_W;
         2'd2:    part_sh = PROD_W'(part) << (2 * CHUNK_W);
         default: part_sh = '0;
      endcase
      rsum = acc_ff + (sh32_ff ? (PROD_W'(1) << 31) : (PROD_W'(1) << 15));
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      sh32_in = sh32_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         sh32_in = sh32;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 2'(NCHUNK)) begin
            res_in  = sh32_ff ? RES_W'(rsum[PROD_W-1:32]) : rsum[PROD_W-1:16];
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            acc_in = acc_ff + part_sh;
            b_in   = b_ff >> CHUNK_W;
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      sh32_ff <= sh32_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule

FILE: hw/rtl/abkf_div.sv
// Restoring divider, one quotient bit per cycle: computes
// round(num * 2^32 / den) on magnitudes. Uses abkf_pkg.
module abkf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [abkf_pkg::NUM_W-1:0]  num,
   input  logic [abkf_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [abkf_pkg::DIVN_W-1:0] quo
);
   import abkf_pkg::*;

   logic               busy_ff, busy_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [DIVN_W-1:0]  n_ff, n_in;
   logic [DIVN_W-1:0]  q_ff, q_in;
   logic [DEN_W:0]     d2_ff, d2_in;
   logic [DEN_W:0]     rem_ff, rem_in;
   logic               done_ff, done_in;
   logic [DEN_W+1:0]   rem_sh;
   logic               ge;

   assign rem_sh = {rem_ff, n_ff[DIVN_W-1]};
   assign ge     = rem_sh >= {1'b0, d2_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      d2_in   = d2_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = DIVN_W'({num, 33'b0}) + DIVN_W'(den);
         q_in    = '0;
         d2_in   = {den, 1'b0};
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, d2_ff}) + (DEN_W+1)'(0)
                     : rem_sh[DEN_W:0];
         q_in   = {q_ff[DIVN_W-2:0], ge};
         n_in   = n_ff << 1;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      q_ff   <= q_in;
      d2_ff  <= d2_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

FILE: hw/rtl/abkf_datapath.sv
// Datapath: filter state, covariance, noise registers, operand selection,
// shared multiplier and divider, write-back and result registers.
// Uses abkf_pkg, abkf_csr_if, abkf_mul and abkf_div.
module abkf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  abkf_pkg::abkf_cmd_type cmd,
   output abkf_pkg::abkf_sts_type sts,
   input  logic signed [31:0]     in_measured_angle,
   input  logic signed [31:0]     in_gyro_rate,
   input  logic [16:0]            in_time_step,
   abkf_csr_if.sink               csr_ch,
   output logic signed [31:0]     filtered_angle,
   output logic signed [31:0]     unbiased_rate
);
   import abkf_pkg::*;

   logic [31:0] q_angle_ff, q_bias_ff, meas_noise_ff;
   logic signed [VAL_W-1:0] meas_ff, gyro_ff;
   logic [DT_W-1:0]         dt_ff;
   logic signed [VAL_W-1:0] angle_ff, angle_in, bias_ff, bias_in, rate_ff, rate_in;
   logic signed [COV_W-1:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [MAG_W-1:0] inner_ff, inner_in;
   logic signed [WIDE_W-1:0] dbb_ff, dbb_in;
   logic signed [DEN_W-1:0] s_ff, s_in;
   logic signed [VAL_W:0]   y_ff, y_in;
   logic signed [COV_W-1:0] p00_ff, p00_in, p01_ff, p01_in;
   logic signed [COV_W-1:0] k0_ff, k0_in, k1_ff, k1_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] fa_ff, ur_ff;

   logic signed [63:0] sa, sb;
   logic               sel_sh32, is_div;
   logic               mul_done, div_done;
   logic [RES_W-1:0]   mul_res;
   logic [DIVN_W-1:0]  div_quo;
   logic signed [63:0] p_wide, p_cov, kq, ang_new;
   logic [MAG_W-1:0]   mag_a, mag_b;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      sa       = '0;
      sb       = '0;
      sel_sh32 = 1'b1;
      is_div   = 1'b0;
      case (cmd.op)
         OP_M_ANG: begin
            sa = 64'($signed({1'b0, dt_ff})); sb = 64'(rate_ff); sel_sh32 = 1'b0;
         end
         OP_M_BB: begin
            sa = 64'($signed({1'b0, dt_ff})); sb = 64'(bb_ff); sel_sh32 = 1'b0;
         end
         OP_M_INNER: begin
            sa = 64'($signed({1'b0, dt_ff})); sb = 64'(inner_ff); sel_sh32 = 1'b0;
         end
         OP_M_QB: begin
            sa = 64'({q_bias_ff, 8'b0}); sb = 64'($signed({1'b0, dt_ff}));
            sel_sh32 = 1'b0;
         end
         OP_D_K0: begin
            sa = 64'(aa_ff); sb = 64'(s_ff); is_div = 1'b1;
         end
         OP_D_K1: begin
            sa = 64'(ba_ff); sb = 64'(s_ff); is_div = 1'b1;
         end
         OP_M_K0Y:   begin sa = 64'(k0_ff); sb = 64'(y_ff);   end
         OP_M_K1Y:   begin sa = 64'(k1_ff); sb = 64'(y_ff);   end
         OP_M_K0P00: begin sa = 64'(k0_ff); sb = 64'(p00_ff); end
         OP_M_K0P01: begin sa = 64'(k0_ff); sb = 64'(p01_ff); end
         OP_M_K1P00: begin sa = 64'(k1_ff); sb = 64'(p00_ff); end
         OP_M_K1P01: begin sa = 64'(k1_ff); sb = 64'(p01_ff); end
         default: ;
      endcase
      mag_a = mag_of(sa);
      mag_b = mag_of(sb);
   end

   abkf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start && !is_div),
      .a     (mag_a),
      .b     (mag_b),
      .sh32  (sel_sh32),
      .done  (mul_done),
      .res   (mul_res)
   );

   abkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start && is_div),
      .num   (mag_a[NUM_W-1:0]),
      .den   (mag_b[DEN_W-1:0]),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign sts.done = mul_done | div_done;

   always_comb begin
      p_wide  = sat_mag(neg_ff, mul_res, WIDE_W);
      p_cov   = sat_mag(neg_ff, mul_res, COV_W);
      kq      = (s_ff == '0) ? 64'sd0 : sat_mag(neg_ff, RES_W'(div_quo), COV_W);
      ang_new = sat_val(64'(angle_ff) + p_wide, VAL_W);
   end

   always_comb begin
      angle_in = angle_ff;
      bias_in  = bias_ff;
      rate_in  = rate_ff;
      aa_in    = aa_ff;
      ab_in    = ab_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      inner_in = inner_ff;
      dbb_in   = dbb_ff;
      s_in     = s_ff;
      y_in     = y_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      neg_in   = neg_ff;
      if (cmd.start) begin
         neg_in = sa[63] ^ sb[63];
      end
      if (cmd.wb) begin
         case (cmd.op)
            OP_LOAD: angle_in = meas_ff;
            OP_RATE: rate_in = VAL_W'(sat_val(64'(gyro_ff) - 64'(bias_ff), VAL_W));
            OP_M_ANG: begin
               angle_in = VAL_W'(ang_new);
               y_in     = (VAL_W+1)'(64'(meas_ff) - ang_new);
            end
            OP_M_BB: begin
               inner_in = MAG_W'(p_cov - 64'(ab_ff) - 64'(ba_ff)
                                 + 64'({q_angle_ff, 8'b0}));
               dbb_in   = WIDE_W'(p_wide);
            end
            OP_M_INNER: begin
               aa_in = COV_W'(sat_val(64'(aa_ff) + p_wide, COV_W));
               ab_in = COV_W'(sat_val(64'(ab_ff) - 64'(dbb_ff), COV_W));
               ba_in = COV_W'(sat_val(64'(ba_ff) - 64'(dbb_ff), COV_W));
            end
            OP_M_QB: begin
               bb_in  = COV_W'(sat_val(64'(bb_ff) + p_wide, COV_W));
               s_in   = DEN_W'(64'(aa_ff) + 64'({meas_noise_ff, 8'b0}));
               p00_in = aa_ff;
               p01_in = ab_ff;
            end
            OP_D_K0:    k0_in = COV_W'(kq);
            OP_D_K1:    k1_in = COV_W'(kq);
            OP_M_K0Y:   angle_in = VAL_W'(ang_new);
            OP_M_K1Y:   bias_in = VAL_W'(sat_val(64'(bias_ff) + p_wide, VAL_W));
            OP_M_K0P00: aa_in = COV_W'(sat_val(64'(aa_ff) - p_wide, COV_W));
            OP_M_K0P01: ab_in = COV_W'(sat_val(64'(ab_ff) - p_wide, COV_W));
            OP_M_K1P00: ba_in = COV_W'(sat_val(64'(ba_ff) - p_wide, COV_W));
            OP_M_K1P01: bb_in = COV_W'(sat_val(64'(bb_ff) - p_wide, COV_W));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff    <= Q_ANGLE_RST;
         q_bias_ff     <= Q_BIAS_RST;
         meas_noise_ff <= MEAS_NOISE_RST;
         angle_ff      <= '0;
         bias_ff       <= '0;
         rate_ff       <= '0;
         aa_ff         <= '0;
         ab_ff         <= '0;
         ba_ff         <= '0;
         bb_ff         <= '0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_idx_type'(csr_ch.index))
               CSR_Q_ANGLE:    q_angle_ff    <= csr_ch.data;
               CSR_Q_BIAS:     q_bias_ff     <= csr_ch.data;
               CSR_MEAS_NOISE: meas_noise_ff <= csr_ch.data;
               default: ;
            endcase
         end
         angle_ff <= angle_in;
         bias_ff  <= bias_in;
         rate_ff  <= rate_in;
         aa_ff    <= aa_in;
         ab_ff    <= ab_in;
         ba_ff    <= ba_in;
         bb_ff    <= bb_in;
      end
      if (cmd.capture) begin
         meas_ff <= in_measured_angle;
         gyro_ff <= in_gyro_rate;
         dt_ff   <= in_time_step;
      end
      if (cmd.emit) begin
         fa_ff <= angle_ff;
         ur_ff <= rate_ff;
      end
      inner_ff <= inner_in;
      dbb_ff   <= dbb_in;
      s_ff     <= s_in;
      y_ff     <= y_in;
      p00_ff   <= p00_in;
      p01_ff   <= p01_in;
      k0_ff    <= k0_in;
      k1_ff    <= k1_in;
      neg_ff   <= neg_in;
   end

   assign filtered_angle = fa_ff;
   assign unbiased_rate  = ur_ff;
endmodule

FILE: hw/rtl/abkf_ctrl.sv
// Controller: accepts a request, walks the operation sequence of a filter
// step or a load, and hands the result to the output register. Uses abkf_pkg.
module abkf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output abkf_pkg::abkf_cmd_type cmd,
   input  abkf_pkg::abkf_sts_type sts
);
   import abkf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WB,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.op       = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_command ? OP_LOAD : OP_RATE;
               state_in    = ST_WB;
            end
         end
         ST_WB: begin
            cmd.wb = 1'b1;
            if (op_ff == OP_LOAD || op_ff == OP_M_K1P01) begin
               state_in = ST_DONE;
            end else begin
               op_in    = next_op(op_ff);
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.done) begin
               state_in = ST_WB;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> state_ff == ST_WAIT)
      else $error("unit done outside wait");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   a_accept_wb: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_WB)
      else $error("accept not followed by write-back");
endmodule

FILE: hw/rtl/angle_bias_kalman_filter.sv
// Two-state Kalman filter for tilt angle and gyro bias.
// Channels: req_ch (command, measured_angle, gyro_rate, time_step), rsp_ch
// (filtered_angle, unbiased_rate), csr_ch (register writes: 0 q_angle,
// 1 q_bias, 2 meas_noise; index 3 ignored). All are valid/ready; a transaction
// completes on a clock edge with both high. csr_ch is always ready; write it
// only while no request is in flight.
// Each request yields exactly one response. A load passes through the
// write-back and done states before its response is loaded. A filter step
// issues, awaits and writes back ten products on the shared 51x17
// multiplier and two gain divisions on the bit-serial divider in turn.
// One request is processed at a time; the next is accepted as soon as the
// previous one has reached the output register, even if rsp_ch is stalled.
// A stalled receiver holds the response; a finished step then waits for the
// output register to free before its response is loaded.
// Reset (synchronous, active high) zeroes estimates and covariance and loads
// the default noise settings.
// Depends on abkf_pkg, abkf_if, abkf_ctrl and abkf_datapath.
module angle_bias_kalman_filter (
   input  logic       clock,
   input  logic       reset,
   abkf_req_if.sink   req_ch,
   abkf_rsp_if.source rsp_ch,
   abkf_csr_if.sink   csr_ch
);
   import abkf_pkg::*;

   abkf_cmd_type cmd;
   abkf_sts_type sts;

   abkf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   abkf_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .in_measured_angle (req_ch.measured_angle),
      .in_gyro_rate      (req_ch.gyro_rate),
      .in_time_step      (req_ch.time_step),
      .csr_ch            (csr_ch),
      .filtered_angle    (rsp_ch.filtered_angle),
      .unbiased_rate     (rsp_ch.unbiased_rate)
   );
endmodule

FILE: test/angle_bias_kalman_filter_tb.sv
// Testbench for the angle/bias Kalman filter: random and directed step and load
// transactions, register writes between phases, and a scoreboard class that predicts each result.
// Depends on abkf_pkg, abkf_if and angle_bias_kalman_filter.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_tb;
   import abkf_pkg::*;

   typedef struct packed {
      logic        command;
      logic [31:0] measured_angle;
      logic [31:0] gyro_rate;
      logic [16:0] time_step;
   } step_txn_type;

   typedef struct packed {
      logic [31:0] filtered_angle;
      logic [31:0] unbiased_rate;
   } tilt_out_type;

   class tilt_scoreboard;
      logic [31:0] q_angle, q_bias, meas_noise;
      longint angle_est, bias_est, rate_est;
      longint p_aa, p_ab, p_ba, p_bb;
      tilt_out_type pending[$];
      int errors;

      function void clear();
         q_angle = Q_ANGLE_RST; q_bias = Q_BIAS_RST; meas_noise = MEAS_NOISE_RST;
         angle_est = 0; bias_est = 0; rate_est = 0;
         p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
         pending.delete(); errors = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [31:0] v);
         case (idx)
            CSR_Q_ANGLE:    q_angle = v;
            CSR_Q_BIAS:     q_bias = v;
            CSR_MEAS_NOISE: meas_noise = v;
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (64'sd1 <<< (w - 1)) - 1;
         lo = -hi - 1;
         return v > hi ? hi : (v < lo ? lo : v);
      endfunction

      function longint clamp_mag(logic neg, logic [127:0] m, int w);
         logic [127:0] lim;
         lim = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
         if (m > lim) m = lim;
         return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
      endfunction

      function logic [63:0] abs64(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function longint mul_round(longint a, longint b, int sh, int w);
         logic [127:0] m;
         m = {64'd0, abs64(a)} * {64'd0, abs64(b)};
         m = (m + (128'd1 << (sh - 1))) >> sh;
         return clamp_mag((a < 0) != (b < 0), m, w);
      endfunction

      function longint div_round(longint num, longint den, int sh, int w);
         logic [127:0] n, d;
         if (den == 0) return 0;
         d = {64'd0, abs64(den)};
         n = ({64'd0, abs64(num)} << (sh + 1)) + d;
         return clamp_mag((num < 0) != (den < 0), n / (d << 1), w);
      endfunction

      function void note_step(step_txn_type t);
         longint meas, dt, qa, qb, rm, inner, s, k0, k1, y, p00, p01;
         meas = longint'($signed(t.measured_angle));
         dt = longint'(t.time_step);
         if (t.command) begin
            angle_est = meas;
         end else begin
            qa = longint'(q_angle) << NOISE_SH;
            qb = longint'(q_bias) << NOISE_SH;
            rm = longint'(meas_noise) << NOISE_SH;
            rate_est = clamp(longint'($signed(t.gyro_rate)) - bias_est, 32);
            angle_est = clamp(angle_est + mul_round(dt, rate_est, 16, 62), 32);
            inner = mul_round(dt, p_bb, 16, 48) - p_ab - p_ba + qa;
            p_aa = clamp(p_aa + mul_round(dt, inner, 16, 62), 48);
            p_ab = clamp(p_ab - mul_round(dt, p_bb, 16, 62), 48);
            p_ba = clamp(p_ba - mul_round(dt, p_bb, 16, 62), 48);
            p_bb = clamp(p_bb + mul_round(qb, dt, 16, 62), 48);
            s = p_aa + rm;
            k0 = div_round(p_aa, s, 32, 48);
            k1 = div_round(p_ba, s, 32, 48);
            y = meas - angle_est;
            angle_est = clamp(angle_est + mul_round(k0, y, 32, 62), 32);
            bias_est = clamp(bias_est + mul_round(k1, y, 32, 62), 32);
            p00 = p_aa; p01 = p_ab;
            p_aa = clamp(p_aa - mul_round(k0, p00, 32, 62), 48);
            p_ab = clamp(p_ab - mul_round(k0, p01, 32, 62), 48);
            p_ba = clamp(p_ba - mul_round(k1, p00, 32, 62), 48);
            p_bb = clamp(p_bb - mul_round(k1, p01, 32, 62), 48);
         end
         pending.push_back({angle_est[31:0], rate_est[31:0]});
      endfunction

      function void check_result(tilt_out_type got);
         tilt_out_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.filtered_angle !== exp_r.filtered_angle) begin
            $error("filtered_angle exp %h got %h", exp_r.filtered_angle, got.filtered_angle);
            errors++;
         end
         if (got.unbiased_rate !== exp_r.unbiased_rate) begin
            $error("unbiased_rate exp %h got %h", exp_r.unbiased_rate, got.unbiased_rate);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   abkf_req_if req_ch ();
   abkf_rsp_if rsp_ch ();
   abkf_csr_if csr_ch ();

   angle_bias_kalman_filter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   tilt_scoreboard sb;
   int send_idle_pct, recv_idle_pct, hold_cycles, quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_step({req_ch.command, req_ch.measured_angle, req_ch.gyro_rate,
                          req_ch.time_step});
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.filtered_angle, rsp_ch.unbiased_rate});
      end
   end

   // receiver: random stall, plus a long hold when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_step(step_txn_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.command, req_ch.measured_angle, req_ch.gyro_rate, req_ch.time_step} <= t;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic step_txn_type rand_step();
      step_txn_type t;
      int sel;
      t.command = ($urandom_range(9) == 0);
      sel = $urandom_range(9);
      t.measured_angle = sel < 6 ? 32'($signed($urandom_range(180 << 16)) - (90 << 16))
                                 : $urandom();
      t.gyro_rate = sel < 6 ? 32'($signed($urandom_range(500 << 16)) - (250 << 16))
                            : $urandom();
      sel = $urandom_range(9);
      t.time_step = sel < 7 ? 17'($urandom_range(3000)) : 17'($urandom_range(65536));
      if (sel == 9) t.time_step = 17'($urandom());
      return t;
   endfunction

   task automatic random_phase(int n);
      repeat (n) send_step(rand_step());
   endtask

   initial begin
      logic [31:0] regs[3];
      sb = new();
      sb.clear();
      quiet_cycles = 0;
      hold_cycles = 0;
      send_idle_pct = 9;
      recv_idle_pct = 55;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = 1'b0;
      req_ch.measured_angle = '0;
      req_ch.gyro_rate = '0;
      req_ch.time_step = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_Q_ANGLE;
      csr_ch.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, load, zero variance, oversize dt
      send_step({1'b0, 32'sd0, 32'sd0, 17'd0});
      send_step({1'b1, 32'h7fffffff, 32'sd0, 17'd0});
      send_step({1'b0, 32'h80000000, 32'h7fffffff, 17'h1ffff});
      send_step({1'b0, 32'h7fffffff, 32'h80000000, 17'd65536});
      send_step({1'b1, 32'h80000000, 32'hffffffff, 17'h1ffff});
      send_step({1'b0, 32'hffffffff, 32'hffffffff, 17'd1});
      send_step({1'b0, 32'h00010000, 32'h00020000, 17'd655});
      drain();
      write_reg(CSR_Q_ANGLE, 32'd0);
      write_reg(CSR_Q_BIAS, 32'd0);
      write_reg(CSR_MEAS_NOISE, 32'd0);
      send_step({1'b1, 32'sd0, 32'sd0, 17'd0});
      send_step({1'b0, 32'h00050000, 32'h00010000, 17'd0});
      send_step({1'b0, 32'h00050000, 32'h00010000, 17'd100});
      drain();
      write_reg(CSR_Q_ANGLE, 32'hffffffff);
      write_reg(CSR_Q_BIAS, 32'hffffffff);
      write_reg(CSR_MEAS_NOISE, 32'hffffffff);
      send_step({1'b0, 32'h12345678, 32'hedcba987, 17'd65536});
      send_step({1'b0, 32'h80000000, 32'h7fffffff, 17'h1ffff});
      send_step({1'b0, 32'h7fffffff, 32'h80000000, 17'h1ffff});
      drain();
      write_reg(CSR_Q_ANGLE, Q_ANGLE_RST);
      write_reg(CSR_Q_BIAS, Q_BIAS_RST);
      write_reg(CSR_MEAS_NOISE, MEAS_NOISE_RST);

      // long receiver hold while requests keep coming
      hold_cycles = 1500;
      random_phase(8);

      random_phase(300);
      drain();
      for (int i = 0; i < 3; i++) regs[i] = $urandom() >> $urandom_range(31);
      write_reg(CSR_Q_ANGLE, regs[0]);
      write_reg(CSR_Q_BIAS, regs[1]);
      write_reg(CSR_MEAS_NOISE, regs[2]);
      send_idle_pct = 55;
      recv_idle_pct = 9;
      random_phase(330);
      drain();
      write_reg(CSR_Q_ANGLE, Q_ANGLE_RST << 2);
      write_reg(CSR_Q_BIAS, Q_BIAS_RST >> 2);
      write_reg(CSR_MEAS_NOISE, 32'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(330);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/abkf_pkg.sv
hw/rtl/abkf_if.sv
hw/rtl/abkf_mul.sv
hw/rtl/abkf_div.sv
hw/rtl/abkf_datapath.sv
hw/rtl/abkf_ctrl.sv
hw/rtl/angle_bias_kalman_filter.sv
test/angle_bias_kalman_filter_tb.sv
